// ----- sv/hdtu_pkg.sv -----
// Shared types and constants for the half-duplex tick-driven UART.
// No dependencies; imported by half_duplex_tick_uart.
package hdtu_pkg;

	localparam int DataBitsDefault = 8;
	localparam int ByteW           = 8;
	localparam int PeriodW         = 16;
	localparam int ActionW         = 3;
	localparam int InDataW         = 16;
	localparam int OutDataW        = 16;
	localparam logic [PeriodW-1:0] PeriodReset = 16'd1;

	typedef enum logic [ActionW-1:0] {
		ACT_TICK     = 3'd0,
		ACT_SEND     = 3'd1,
		ACT_EDGE     = 3'd2,
		ACT_CLR_TX   = 3'd3,
		ACT_CLR_RX   = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_SEND = 2'd1,
		MODE_RECV = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		PHASE_START = 2'd0,
		PHASE_DATA  = 2'd1,
		PHASE_STOP  = 2'd2
	} phase_t;

endpackage

// ----- sv/half_duplex_tick_uart.sv -----
// Half-duplex tick-driven UART, 8N1 framing, LSB first, one request per tick/event.
// Depends on hdtu_pkg for action, mode and phase codes.
//
// A result is registered when its request is accepted, in the skid if the output is stalled.
// One request per cycle unless the skid is full; the state update is one combinational pass.
// A two-entry output buffer (result register plus skid) keeps s_tready independent of m_tready.
// Reset (arst_n low, asynchronous): idle, line high, tx_done set, period 1, buffers empty.
module half_duplex_tick_uart #(
	parameter int DATA_BITS = hdtu_pkg::DataBitsDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hdtu_pkg::PeriodW-1:0]  cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [7:0] tx_byte, [8] rx_level, [15:9] zero
	input  logic [hdtu_pkg::InDataW-1:0]  s_tdata,
	// [2:0] action
	input  logic [hdtu_pkg::ActionW-1:0]  s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [0] tx_level, [8:1] rx_byte, [9] tx_done, [10] rx_done, [12:11] busy_mode,
	// [13] refused, [15:14] zero
	output logic [hdtu_pkg::OutDataW-1:0] m_tdata
);
	import hdtu_pkg::*;

	localparam logic [3:0] LastBits = 4'(DATA_BITS);

	logic [PeriodW-1:0]  period_q;
	mode_t               mode_q, mode_d;
	phase_t              phase_q, phase_d;
	logic [3:0]          bit_idx_q, bit_idx_d;
	logic [PeriodW-1:0]  tick_q, tick_d;
	logic [ByteW-1:0]    tx_hold_q, tx_hold_d;
	logic [ByteW-1:0]    rx_hold_q, rx_hold_d;
	logic                line_q, line_d;
	logic                tx_done_q, tx_done_d;
	logic                rx_done_q, rx_done_d;
	logic                refused_d;
	logic [PeriodW:0]    tick_inc;
	logic [3:0]          bit_inc;
	logic [ByteW-1:0]    in_byte;
	logic                in_level;
	logic [OutDataW-1:0] res_d, out_q, skid_q;
	logic                out_valid_q, skid_valid_q;
	logic                accept, pop;

	assign in_byte  = s_tdata[ByteW-1:0];
	assign in_level = s_tdata[ByteW];
	assign tick_inc = {1'b0, tick_q} + {{PeriodW{1'b0}}, 1'b1};
	assign bit_inc  = bit_idx_q + 4'd1;

	always_comb begin
		mode_d    = mode_q;
		phase_d   = phase_q;
		bit_idx_d = bit_idx_q;
		tick_d    = tick_q;
		tx_hold_d = tx_hold_q;
		rx_hold_d = rx_hold_q;
		line_d    = line_q;
		tx_done_d = tx_done_q;
		rx_done_d = rx_done_q;
		refused_d = 1'b0;
		unique case (action_t'(s_tuser))
			ACT_TICK: begin
				if (tick_inc < {1'b0, period_q}) begin
					tick_d = tick_inc[PeriodW-1:0];
				end else begin
					tick_d = '0;
					unique case (mode_q)
						MODE_IDLE: line_d = 1'b1;
						MODE_SEND: begin
							unique case (phase_q)
								PHASE_START: begin
									line_d  = 1'b0;
									phase_d = PHASE_DATA;
								end
								PHASE_DATA: begin
									line_d    = bit_idx_q[3] ? 1'b0 : tx_hold_q[bit_idx_q[2:0]];
									bit_idx_d = bit_inc;
									if (bit_inc == LastBits) begin
										bit_idx_d = '0;
										phase_d   = PHASE_STOP;
									end
								end
								default: begin
									line_d    = 1'b1;
									phase_d   = PHASE_START;
									mode_d    = MODE_IDLE;
									tx_done_d = 1'b1;
									bit_idx_d = '0;
								end
							endcase
						end
						MODE_RECV: begin
							unique case (phase_q)
								PHASE_START: begin
									phase_d   = PHASE_DATA;
									rx_hold_d = '0;
								end
								PHASE_DATA: begin
									if (!bit_idx_q[3]) begin
										rx_hold_d[bit_idx_q[2:0]] = rx_hold_q[bit_idx_q[2:0]] | in_level;
									end
									bit_idx_d = bit_inc;
									if (bit_inc == LastBits) begin
										bit_idx_d = '0;
										phase_d   = PHASE_STOP;
									end
								end
								default: begin
									mode_d    = MODE_IDLE;
									rx_done_d = 1'b1;
									phase_d   = PHASE_START;
									bit_idx_d = '0;
								end
							endcase
						end
						default: ;
					endcase
				end
			end
			ACT_SEND: begin
				if (mode_q == MODE_IDLE) begin
					tx_hold_d = in_byte;
					mode_d    = MODE_SEND;
				end else begin
					refused_d = 1'b1;
				end
			end
			ACT_EDGE: begin
				if (mode_q == MODE_IDLE) begin
					mode_d = MODE_RECV;
					tick_d = period_q >> 1;
				end else begin
					refused_d = 1'b1;
				end
			end
			ACT_CLR_TX: tx_done_d = 1'b0;
			ACT_CLR_RX: rx_done_d = 1'b0;
			default: ;
		endcase
		res_d = {2'b00, refused_d, mode_d, rx_done_d, tx_done_d, rx_hold_d, line_d};
	end

	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign pop      = out_valid_q && m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= PeriodReset;
			mode_q    <= MODE_IDLE;
			phase_q   <= PHASE_START;
			bit_idx_q <= '0;
			tick_q    <= '0;
			tx_hold_q <= '0;
			rx_hold_q <= '0;
			line_q    <= 1'b1;
			tx_done_q <= 1'b1;
			rx_done_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			if (accept) begin
				mode_q    <= mode_d;
				phase_q   <= phase_d;
				bit_idx_q <= bit_idx_d;
				tick_q    <= tick_d;
				tx_hold_q <= tx_hold_d;
				rx_hold_q <= rx_hold_d;
				line_q    <= line_d;
				tx_done_q <= tx_done_d;
				rx_done_q <= rx_done_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (out_valid_q && !pop) begin
				skid_q <= res_d;
			end else begin
				out_q <= res_d;
			end
		end else if (pop && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

endmodule

// ----- tb/tb_half_duplex_tick_uart.sv -----
// Self-checking testbench for half_duplex_tick_uart: directed table then random ticks and events,
// every result checked against a typed table row or a cycle-free 8N1 transmit/receive model.
// Depends on hdtu_pkg and half_duplex_tick_uart.
`timescale 1ns / 100ps

module tb_half_duplex_tick_uart;
	import hdtu_pkg::*;

	localparam int NBITS = DataBitsDefault;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int RUN_COUNT = 9;
	localparam logic [ActionW-1:0] ACT_RSVD_FIRST = ActionW'(ACT_CLR_RX + 1);
	localparam logic [ActionW-1:0] ACT_RSVD_LAST = '1;
	localparam logic [PeriodW-1:0] RUN_PERIOD [RUN_COUNT] = '{
		16'd2, 16'd0, 16'd3, 16'hFFFF, 16'd1, 16'd5, 16'hFFFE, 16'd4, 16'd7
	};

	typedef struct packed {
		logic       refused;
		mode_t      busy_mode;
		logic       rx_done;
		logic       tx_done;
		logic [7:0] rx_byte;
		logic       tx_level;
	} uart_status_t;

	typedef struct packed {
		logic [ActionW-1:0] act;
		logic [ByteW-1:0]   tx_byte;
		logic               rx_level;
	} uart_req_t;

	typedef struct {
		uart_req_t    req;
		int unsigned  reps;
		bit           typed;
		uart_status_t want;
	} dir_row_t;

	localparam uart_status_t ST_RESET = '{refused: 1'b0, busy_mode: MODE_IDLE, rx_done: 1'b0,
		tx_done: 1'b1, rx_byte: 8'h00, tx_level: 1'b1};
	localparam uart_status_t ST_TXCLR = '{refused: 1'b0, busy_mode: MODE_IDLE, rx_done: 1'b0,
		tx_done: 1'b0, rx_byte: 8'h00, tx_level: 1'b1};
	localparam uart_status_t ST_SENDING = '{refused: 1'b0, busy_mode: MODE_SEND, rx_done: 1'b0,
		tx_done: 1'b0, rx_byte: 8'h00, tx_level: 1'b1};
	localparam uart_status_t ST_REFUSED = '{refused: 1'b1, busy_mode: MODE_SEND, rx_done: 1'b0,
		tx_done: 1'b0, rx_byte: 8'h00, tx_level: 1'b1};

	localparam int DIR_ROWS = 16;
	dir_row_t dir_tab [DIR_ROWS] = '{
		'{'{ACT_TICK,       8'h00, 1'b0}, 1,  1'b1, ST_RESET},
		'{'{ACT_TICK,       8'hFF, 1'b1}, 1,  1'b1, ST_RESET},
		'{'{ACT_CLR_TX,     8'h00, 1'b0}, 1,  1'b1, ST_TXCLR},
		'{'{ACT_CLR_RX,     8'h00, 1'b0}, 1,  1'b1, ST_TXCLR},
		'{'{ACT_RSVD_LAST,  8'hFF, 1'b1}, 1,  1'b1, ST_TXCLR},
		'{'{ACT_SEND,       8'h96, 1'b0}, 1,  1'b1, ST_SENDING},
		'{'{ACT_SEND,       8'h00, 1'b0}, 1,  1'b1, ST_REFUSED},
		'{'{ACT_EDGE,       8'h00, 1'b0}, 1,  1'b1, ST_REFUSED},
		'{'{ACT_TICK,       8'h00, 1'b1}, 10, 1'b0, ST_RESET},
		'{'{ACT_EDGE,       8'h00, 1'b0}, 1,  1'b0, ST_RESET},
		'{'{ACT_TICK,       8'h00, 1'b0}, 2,  1'b0, ST_RESET},
		'{'{ACT_TICK,       8'h00, 1'b1}, 3,  1'b0, ST_RESET},
		'{'{ACT_TICK,       8'h00, 1'b0}, 1,  1'b0, ST_RESET},
		'{'{ACT_TICK,       8'h00, 1'b1}, 3,  1'b0, ST_RESET},
		'{'{ACT_TICK,       8'h00, 1'b0}, 1,  1'b0, ST_RESET},
		'{'{ACT_CLR_RX,     8'h00, 1'b0}, 1,  1'b0, ST_RESET}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [PeriodW-1:0]    cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [InDataW-1:0]    s_tdata;
	logic [ActionW-1:0]    s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OutDataW-1:0]   m_tdata;

	// model state
	logic [PeriodW-1:0] period_q;
	mode_t              mode_q;
	phase_t             phase_q;
	logic [3:0]         bitidx_q;
	logic [PeriodW-1:0] ticks_q;
	logic [ByteW-1:0]   txh_q;
	logic [ByteW-1:0]   rxh_q;
	logic               line_q;
	logic               txd_q;
	logic               rxd_q;

	uart_status_t want_status_q [$];
	int unsigned  mismatch_cnt = 0;
	int unsigned  quiet_cycles = 0;
	int unsigned  hold_left = 0;
	bit           hold_req = 1'b0;
	bit           steady = 1'b0;

	half_duplex_tick_uart DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic uart_status_t uart_predict(input uart_req_t req);
		logic [PeriodW:0] nxt;
		uart_status_t st;
		st.refused = 1'b0;
		case (req.act)
		ACT_TICK: begin
			nxt = {1'b0, ticks_q} + 1'b1;
			if (nxt < {1'b0, period_q}) begin
				ticks_q = nxt[PeriodW-1:0];
			end else begin
				ticks_q = '0;
				case (mode_q)
				MODE_IDLE: line_q = 1'b1;
				MODE_SEND: begin
					case (phase_q)
					PHASE_START: begin
						line_q = 1'b0;
						phase_q = PHASE_DATA;
					end
					PHASE_DATA: begin
						line_q = (bitidx_q < ByteW) ? txh_q[bitidx_q[2:0]] : 1'b0;
						bitidx_q = bitidx_q + 1'b1;
						if (bitidx_q == 4'(NBITS)) begin
							bitidx_q = '0;
							phase_q = PHASE_STOP;
						end
					end
					default: begin
						line_q = 1'b1;
						phase_q = PHASE_START;
						mode_q = MODE_IDLE;
						txd_q = 1'b1;
						bitidx_q = '0;
					end
					endcase
				end
				MODE_RECV: begin
					case (phase_q)
					PHASE_START: begin
						phase_q = PHASE_DATA;
						rxh_q = '0;
					end
					PHASE_DATA: begin
						if (bitidx_q < ByteW)
							rxh_q[bitidx_q[2:0]] = rxh_q[bitidx_q[2:0]] | req.rx_level;
						bitidx_q = bitidx_q + 1'b1;
						if (bitidx_q == 4'(NBITS)) begin
							bitidx_q = '0;
							phase_q = PHASE_STOP;
						end
					end
					default: begin
						mode_q = MODE_IDLE;
						rxd_q = 1'b1;
						phase_q = PHASE_START;
						bitidx_q = '0;
					end
					endcase
				end
				default: ;
				endcase
			end
		end
		ACT_SEND: begin
			if (mode_q == MODE_IDLE) begin
				txh_q = req.tx_byte;
				mode_q = MODE_SEND;
			end else begin
				st.refused = 1'b1;
			end
		end
		ACT_EDGE: begin
			if (mode_q == MODE_IDLE) begin
				mode_q = MODE_RECV;
				ticks_q = period_q >> 1;
			end else begin
				st.refused = 1'b1;
			end
		end
		ACT_CLR_TX: txd_q = 1'b0;
		ACT_CLR_RX: rxd_q = 1'b0;
		default: ;
		endcase
		st.tx_level = line_q;
		st.rx_byte = rxh_q;
		st.tx_done = txd_q;
		st.rx_done = rxd_q;
		st.busy_mode = mode_q;
		return st;
	endfunction

	task automatic offer_request(input uart_req_t req, input bit typed, input uart_status_t want);
		uart_status_t st;
		while (!steady && $urandom_range(99) < 31) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req.act;
		s_tdata <= {{(InDataW-ByteW-1){1'b0}}, req.rx_level, req.tx_byte};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		st = uart_predict(req);
		want_status_q.push_back(typed ? want : st);
	endtask

	task automatic write_period(input logic [PeriodW-1:0] value);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (want_status_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		period_q = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic uart_req_t random_request();
		uart_req_t req;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 66)
			req.act = ACT_TICK;
		else if (pick < 76)
			req.act = ACT_SEND;
		else if (pick < 86)
			req.act = ACT_EDGE;
		else if (pick < 92)
			req.act = ACT_CLR_TX;
		else if (pick < 98)
			req.act = ACT_CLR_RX;
		else
			req.act = ActionW'($urandom_range(ACT_RSVD_LAST, ACT_RSVD_FIRST));
		req.tx_byte = ByteW'($urandom);
		req.rx_level = 1'($urandom);
		return req;
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			mismatch_cnt++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	initial begin
		uart_status_t want;
		uart_status_t got;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = uart_status_t'(m_tdata[$bits(uart_status_t)-1:0]);
				if (want_status_q.size() == 0) begin
					mismatch_cnt++;
					$display("%0t: result expected none actual %0h", $time, m_tdata);
				end else begin
					want = want_status_q.pop_front();
					check_field("tx_level", want.tx_level, got.tx_level);
					check_field("rx_byte", want.rx_byte, got.rx_byte);
					check_field("tx_done", want.tx_done, got.tx_done);
					check_field("rx_done", want.rx_done, got.rx_done);
					check_field("busy_mode", want.busy_mode, got.busy_mode);
					check_field("refused", want.refused, got.refused);
				end
			end
		end
	end

	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (steady) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 31);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("tb_half_duplex_tick_uart failed");
				$finish;
			end
		end
	end

	initial begin
		int unsigned n_items;
		logic [PeriodW-1:0] per;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= ACT_TICK;
		period_q = PeriodReset;
		mode_q = MODE_IDLE;
		phase_q = PHASE_START;
		bitidx_q = '0;
		ticks_q = '0;
		txh_q = '0;
		rxh_q = '0;
		line_q = 1'b1;
		txd_q = 1'b1;
		rxd_q = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++)
			for (int k = 0; k < dir_tab[r].reps; k++)
				offer_request(dir_tab[r].req, dir_tab[r].typed, dir_tab[r].want);

		for (int p = 0; p < RUN_COUNT; p++) begin
			per = (p == RUN_COUNT - 1) ? PeriodW'($urandom_range(12, 1)) : RUN_PERIOD[p];
			write_period(per);
			steady = (p == 4);
			n_items = (per > 16'd255) ? 40 : 150;
			for (int i = 0; i < n_items; i++) begin
				// hold the receiver off while requests keep coming
				if (p == 2 && i == 20)
					hold_req = 1'b1;
				offer_request(random_request(), 1'b0, ST_RESET);
			end
		end
		steady = 1'b0;

		s_tvalid <= 1'b0;
		while (want_status_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("tb_half_duplex_tick_uart passed");
		else
			$display("tb_half_duplex_tick_uart failed");
		$finish;
	end

endmodule
